/* sv/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Constants and the LFSR step function shared by the paged frame allocator modules.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam logic [1:0] REQ_ADD       = 2'd0;
  localparam logic [1:0] REQ_TRANSLATE = 2'd1;
  localparam logic [1:0] REQ_DELETE    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic CFG_PAGE_MB     = 1'b0;
  localparam logic CFG_FRAME_COUNT = 1'b1;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // Advance a 16-bit Fibonacci LFSR, taps 16,14,13,11
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[15:1]};
  endfunction

endpackage

/* sv/paged_frame_allocator.sv */
// One request is handled at a time. A translate reads one page-table entry; a delete
// scans the owner of every frame; an add divides the size by the page size, then per
// page reduces the LFSR modulo free_count by subtracting 64x or 1x free_count and
// compacts the free list one entry at a time.
// The next request can be taken in the cycle after the result transfer.
// Reset and frame_count writes run a clearing sweep over all FRAMES entries with in_ready low.
// ----------------------------------------------------------------------------
// paged_frame_allocator
// Paging frame allocator with add, translate and delete requests.
// ----------------------------------------------------------------------------
module paged_frame_allocator
  import pfa_pkg::*;
#(
  parameter int MAX_PROC = 10,
  parameter int FRAMES   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] size_mb,
  input  logic [15:0] process_id,
  input  logic [5:0]  page_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  frame_number,
  output logic [15:0] assigned_id,
  output logic [6:0]  free_frames
);

  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int SW = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
  localparam int PW = SW + FW;

  typedef enum logic [13:0] {
    S_CLEAR   = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_DIVW    = 14'b00000000000100,
    S_SLOT    = 14'b00000000001000,
    S_MOD     = 14'b00000000010000,
    S_RDPOS   = 14'b00000000100000,
    S_PLACE   = 14'b00000001000000,
    S_SHIFT   = 14'b00000010000000,
    S_SHWR    = 14'b00000100000000,
    S_TRRD    = 14'b00001000000000,
    S_TRWAIT  = 14'b00010000000000,
    S_DELRD   = 14'b00100000000000,
    S_DELSCAN = 14'b01000000000000,
    S_OUT     = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration
  logic [12:0] page_mb;
  logic [CW-1:0] frame_count;
  logic [CW-1:0] fc_clamp;
  always_comb begin
    if (cfg_data[6:0] == 7'd0) fc_clamp = CW'(1);
    else if ({25'd0, cfg_data[6:0]} > 32'(FRAMES)) fc_clamp = CW'(FRAMES);
    else fc_clamp = CW'(cfg_data[6:0]);
  end
  logic fc_write;
  assign fc_write = cfg_we && (cfg_index == CFG_FRAME_COUNT);

  // Memories
  logic [FW-1:0] free_list [FRAMES];
  logic [FW-1:0] page_tab  [MAX_PROC*FRAMES];
  logic [SW:0]   own_tab   [FRAMES];

  logic [15:0]   slot_idv  [MAX_PROC];
  logic          slot_v    [MAX_PROC];
  logic [6:0]    slot_pg   [MAX_PROC];

  logic [CW-1:0] free_count;
  logic [15:0]   id_counter;
  logic [15:0]   lfsr;

  // Working registers
  logic [1:0]    req;
  logic [15:0]   pid;
  logic [5:0]    pno;
  logic [16:0]   pages;
  logic [6:0]    page_idx;
  logic [SW-1:0] slot;
  logic [SW:0]   scan;
  logic          found;
  logic [15:0]   modv;
  logic [FW:0]   idx;
  logic [FW-1:0] rd_data;
  logic [FW-1:0] pt_data;

  // Request handshake
  logic in_xfer;
  assign in_ready = (state == S_IDLE) && !out_valid && !cfg_we;
  assign in_xfer  = in_valid && in_ready;

  // Divider for the page count
  logic        div_start;
  logic        div_done;
  logic [15:0] dquo, drem;
  logic [12:0] ps_eff;
  assign ps_eff = (page_mb == 13'd0) ? 13'd1 : page_mb;
  pfa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(size_mb),
    .divisor(ps_eff), .done(div_done),
    .quotient(dquo), .remainder(drem)
  );
  assign div_start = in_xfer && (req_type == REQ_ADD);

  // Free list memory: one write, one read per cycle
  logic          fl_we;
  logic [FW-1:0] fl_wa, fl_ra, fl_wd;
  always_ff @(posedge clk) begin
    if (fl_we) free_list[fl_wa] <= fl_wd;
    rd_data <= free_list[fl_ra];
  end

  // Page table memory
  logic          pt_we;
  logic [PW-1:0] pt_wa, pt_ra;
  logic [FW-1:0] pt_wd;
  always_ff @(posedge clk) begin
    if (pt_we) page_tab[pt_wa] <= pt_wd;
    pt_data <= page_tab[pt_ra];
  end

  logic [FW-1:0] idx_f;
  assign idx_f = idx[FW-1:0];

  // Frame owner memory: {valid, slot}, read at the scan index
  logic          own_we;
  logic [FW-1:0] own_wa;
  logic [SW:0]   own_wd;
  logic [SW:0]   own_rd;
  always_ff @(posedge clk) begin
    if (own_we) own_tab[own_wa] <= own_wd;
    own_rd <= own_tab[idx_f];
  end

  // Frame under scan belongs to the slot being deleted
  logic del_hit;
  assign del_hit = (idx < (FW+1)'(frame_count)) && own_rd[SW] && (own_rd[SW-1:0] == slot);

  always_comb begin
    fl_we = 1'b0;
    fl_wa = idx_f;
    fl_wd = idx_f;
    fl_ra = idx_f;
    pt_we = 1'b0;
    pt_wa = PW'(slot) * PW'(FRAMES) + PW'(page_idx[FW-1:0]);
    pt_wd = rd_data;
    pt_ra = PW'(slot) * PW'(FRAMES) + PW'(pno[FW-1:0]);
    own_we = 1'b0;
    own_wa = idx_f;
    own_wd = '0;
    unique case (state)
      S_CLEAR: begin fl_we = 1'b1; own_we = 1'b1; end
      S_RDPOS: fl_ra = modv[FW-1:0];
      S_PLACE: begin
        pt_we  = 1'b1;
        own_we = 1'b1;
        own_wa = rd_data;
        own_wd = {1'b1, slot};
      end
      S_SHIFT: fl_ra = FW'(idx + 1'b1);
      S_SHWR:  begin fl_we = 1'b1; fl_wd = rd_data; fl_ra = FW'(idx + 1'b1); end
      S_DELSCAN: begin
        own_we = del_hit;
        fl_we  = del_hit && (free_count < CW'(FRAMES));
        fl_wa  = free_count[FW-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      page_mb     <= 13'd1;
      frame_count <= CW'(FRAMES < 64 ? FRAMES : 64);
      free_count  <= CW'(FRAMES < 64 ? FRAMES : 64);
      id_counter  <= '0;
      lfsr        <= LFSR_SEED;
      out_valid   <= 1'b0;
      for (int i = 0; i < MAX_PROC; i++) slot_v[i] <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we && cfg_index == CFG_PAGE_MB) page_mb <= cfg_data;
      if (fc_write) begin
        frame_count <= fc_clamp;
        free_count  <= fc_clamp;
        id_counter  <= '0;
        for (int i = 0; i < MAX_PROC; i++) begin
          slot_v[i] <= 1'b0; slot_pg[i] <= '0; slot_idv[i] <= '0;
        end
        state <= S_CLEAR;
        idx   <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            if (idx == (FW+1)'(FRAMES - 1)) state <= S_IDLE;
            idx <= idx + 1'b1;
          end
          S_IDLE: if (in_xfer) begin
            req <= req_type; pid <= process_id; pno <= page_number;
            scan <= '0; found <= 1'b0;
            status <= ST_INVALID; frame_number <= '0; assigned_id <= '0;
            unique case (req_type)
              REQ_ADD: begin
                assigned_id <= (id_counter != 16'hFFFF) ? id_counter + 16'd1 : id_counter;
                if (id_counter != 16'hFFFF) id_counter <= id_counter + 16'd1;
                state <= S_DIVW;
              end
              REQ_TRANSLATE, REQ_DELETE: state <= S_SLOT;
              default: state <= S_OUT;
            endcase
          end
          S_DIVW: if (div_done) begin
            pages <= {1'b0, dquo} + ((drem != 16'd0) ? 17'd1 : 17'd0);
            if ({1'b0, dquo} + ((drem != 16'd0) ? 17'd1 : 17'd0) > 17'(free_count)) begin
              status <= ST_NO_FRAME; state <= S_OUT;
            end else state <= S_SLOT;
          end
          // Search slots one per cycle
          S_SLOT: begin
            if (!found && scan < (SW+1)'(MAX_PROC)) begin
              if (req == REQ_ADD ? !slot_v[SW'(scan)]
                  : (slot_v[SW'(scan)] && slot_idv[SW'(scan)] == pid)) begin
                found <= 1'b1; slot <= SW'(scan);
              end
              scan <= scan + 1'b1;
            end else if (!found) begin
              status <= (req == REQ_ADD) ? ST_NO_SLOT : ST_INVALID;
              state <= S_OUT;
            end else if (req == REQ_ADD) begin
              slot_v[slot] <= 1'b1; slot_idv[slot] <= assigned_id;
              slot_pg[slot] <= pages[6:0];
              page_idx <= '0; status <= ST_OK;
              if (pages == 17'd0 || free_count == '0) state <= S_OUT;
              else begin lfsr <= lfsr_step(lfsr); modv <= lfsr_step(lfsr); state <= S_MOD; end
            end else if (req == REQ_TRANSLATE) begin
              if ({1'b0, pno} < slot_pg[slot]) state <= S_TRRD;
              else state <= S_OUT;
            end else begin
              slot_v[slot] <= 1'b0; slot_idv[slot] <= '0; slot_pg[slot] <= '0;
              status <= ST_OK; idx <= '0; state <= S_DELRD;
            end
          end
          // Reduce lfsr modulo free_count by repeated subtraction of free_count, shifted left by 6 while it fits
          S_MOD: begin
            if (modv >= 16'(free_count)) begin
              if (modv >= (16'(free_count) << 6)) modv <= modv - (16'(free_count) << 6);
              else modv <= modv - 16'(free_count);
            end else state <= S_RDPOS;
          end
          S_RDPOS: begin idx <= (FW+1)'(modv); state <= S_PLACE; end
          S_PLACE: state <= S_SHIFT;
          S_SHIFT: state <= S_SHWR;
          // Compact: list[idx] <= list[idx+1], each move reading in S_SHIFT and writing in S_SHWR
          S_SHWR: begin
            if ((idx + 2'd2) <= (FW+1)'(free_count)) begin
              idx <= idx + 1'b1;
              state <= S_SHIFT;
            end else begin
              free_count <= free_count - 1'b1;
              page_idx   <= page_idx + 1'b1;
              if ({10'd0, page_idx} + 17'd1 >= pages || free_count == CW'(1)) state <= S_OUT;
              else begin lfsr <= lfsr_step(lfsr); modv <= lfsr_step(lfsr); state <= S_MOD; end
            end
          end
          S_TRRD: state <= S_TRWAIT;
          S_TRWAIT: begin status <= ST_OK; frame_number <= 6'(pt_data); state <= S_OUT; end
          // Read the owner of one frame, then return it if the slot owned it
          S_DELRD: state <= S_DELSCAN;
          S_DELSCAN: begin
            if (fl_we) free_count <= free_count + 1'b1;
            if (idx == (FW+1)'(FRAMES - 1)) state <= S_OUT;
            else state <= S_DELRD;
            idx <= idx + 1'b1;
          end
          S_OUT: begin out_valid <= 1'b1; free_frames <= 7'(free_count); state <= S_IDLE; end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

/* sv/pfa_div.sv */
// ----------------------------------------------------------------------------
// pfa_div
// Radix-2 restoring divider, one quotient bit per cycle, 16 quotient bits.
// ----------------------------------------------------------------------------
module pfa_div
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);

  logic        busy;
  logic [4:0]  count;
  logic [15:0] quo;
  logic [15:0] rem;
  logic [12:0] dsr;
  logic [16:0] trial;

  assign trial = {rem, quo[15]};

  // Shift and subtract one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd16;
        quo   <= dividend;
        rem   <= '0;
        dsr   <= divisor;
      end else if (busy) begin
        if (trial >= {4'd0, dsr}) begin
          rem <= 16'(trial - {4'd0, dsr});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b0};
        end
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* bench/pfa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfa_checker
// Watches the request, result and register ports of the frame allocator,
// predicts each result from its own copy of the allocator state and compares
// every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module pfa_checker
  import pfa_pkg::*;
#(
  parameter int MAX_PROC = 10,
  parameter int FRAMES   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] size_mb,
  input  logic [15:0] process_id,
  input  logic [5:0]  page_number,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [5:0]  frame_number,
  input  logic [15:0] assigned_id,
  input  logic [6:0]  free_frames,
  output int          errors,
  output int          waiting
);

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  frame;
    logic [15:0] aid;
    logic [6:0]  free;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  // Allocator shadow state
  logic [12:0] pg_size;
  int          frames_used;
  int          free_list[FRAMES];
  int          free_cnt;
  bit          owned[FRAMES];
  int          owner_slot[FRAMES];
  bit          slot_used[MAX_PROC];
  logic [15:0] slot_pid[MAX_PROC];
  int          slot_npages[MAX_PROC];
  int          page_map[MAX_PROC][FRAMES];
  logic [15:0] id_ctr;
  logic [15:0] lfsr;

  // Clear the frame tables and slots; the LFSR keeps running
  function automatic void clear_tables();
    for (int i = 0; i < FRAMES; i++) begin
      free_list[i] = i;
      owned[i] = 0;
      owner_slot[i] = 0;
    end
    free_cnt = frames_used;
    for (int s = 0; s < MAX_PROC; s++) begin
      slot_used[s] = 0;
      slot_pid[s] = '0;
      slot_npages[s] = 0;
    end
    id_ctr = '0;
  endfunction

  function automatic int lookup_slot(logic [15:0] pid);
    for (int s = 0; s < MAX_PROC; s++)
      if (slot_used[s] && slot_pid[s] == pid) return s;
    return -1;
  endfunction

  // Work out the result of one request and update the shadow state
  function automatic alloc_result_t allocate_step(logic [1:0] kind, logic [15:0] psize,
                                                  logic [15:0] pid, logic [5:0] pno);
    alloc_result_t r;
    int ps, pages, s, pos, f;
    logic b;
    r.status = ST_INVALID;
    r.frame = '0;
    r.aid = '0;
    case (kind)
      REQ_ADD: begin
        ps = (pg_size == 0) ? 1 : int'(pg_size);
        pages = int'(psize) / ps + ((int'(psize) % ps != 0) ? 1 : 0);
        if (id_ctr != 16'hFFFF) id_ctr = id_ctr + 16'd1;
        r.aid = id_ctr;
        if (pages > free_cnt) begin
          r.status = ST_NO_FRAME;
        end else begin
          s = -1;
          for (int k = 0; k < MAX_PROC; k++)
            if (s < 0 && !slot_used[k]) s = k;
          if (s < 0) begin
            r.status = ST_NO_SLOT;
          end else begin
            slot_used[s] = 1;
            slot_pid[s] = id_ctr;
            slot_npages[s] = pages;
            for (int j = 0; j < pages && free_cnt > 0; j++) begin
              b = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
              lfsr = {b, lfsr[15:1]};
              pos = int'(lfsr) % free_cnt;
              f = free_list[pos] % FRAMES;
              page_map[s][j % FRAMES] = f;
              owned[f] = 1;
              owner_slot[f] = s;
              // close the gap
              for (int k = pos; k + 1 < free_cnt; k++) free_list[k] = free_list[k + 1];
              free_cnt--;
            end
            r.status = ST_OK;
          end
        end
      end
      REQ_TRANSLATE: begin
        s = lookup_slot(pid);
        if (s >= 0 && int'(pno) < slot_npages[s]) begin
          r.status = ST_OK;
          r.frame = 6'(page_map[s][pno]);
        end
      end
      REQ_DELETE: begin
        s = lookup_slot(pid);
        if (s >= 0) begin
          slot_used[s] = 0;
          slot_pid[s] = '0;
          slot_npages[s] = 0;
          // return owned frames in ascending order
          for (int k = 0; k < frames_used && k < FRAMES; k++)
            if (owned[k] && owner_slot[k] == s) begin
              owned[k] = 0;
              owner_slot[k] = 0;
              if (free_cnt < FRAMES) begin
                free_list[free_cnt] = k;
                free_cnt++;
              end
            end
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.free = 7'(free_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r;
    int v;
    if (rst) begin
      pg_size = 13'd1;
      frames_used = (FRAMES < 64) ? FRAMES : 64;
      lfsr = LFSR_SEED;
      clear_tables();
      expected_results.delete();
      errors <= 0;
      waiting <= 0;
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_PAGE_MB) begin
          pg_size = cfg_data;
        end else begin
          v = int'(cfg_data[6:0]);
          if (v == 0) v = 1;
          if (v > FRAMES) v = FRAMES;
          frames_used = v;
          clear_tables();
        end
      end
      // predict on each request transfer
      if (in_valid && in_ready)
        expected_results.push_back(allocate_step(req_type, size_mb, process_id,
                                                 page_number));
      // compare each result transfer
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status);
            errors <= errors + 1;
          end else if (frame_number !== exp_r.frame) begin
            $error("frame_number: expected %0d, actual %0d", exp_r.frame, frame_number);
            errors <= errors + 1;
          end else if (assigned_id !== exp_r.aid) begin
            $error("assigned_id: expected %0d, actual %0d", exp_r.aid, assigned_id);
            errors <= errors + 1;
          end else if (free_frames !== exp_r.free) begin
            $error("free_frames: expected %0d, actual %0d", exp_r.free, free_frames);
            errors <= errors + 1;
          end
        end
      end
      waiting <= expected_results.size();
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the paged frame allocator: directed adds, translates and
// deletes including slot overflow and slot reuse, then random requests
// across several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import pfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [15:0] size_mb;
  logic [15:0] process_id;
  logic [5:0]  page_number;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [5:0]  frame_number;
  logic [15:0] assigned_id;
  logic [6:0]  free_frames;
  int          errors;
  int          waiting;
  bit          calm;
  int          quiet_cycles;
  logic [15:0] next_pid;
  int          cur_psize;

  paged_frame_allocator u_dut (.*);
  pfa_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Drain stalls in random bursts; none once calm
  initial begin
    out_ready = 1;
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1;
      end
    end
  end

  // Abort when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("paged_frame_allocator: mismatch");
      $finish;
    end
  end

  // Present one request and hold it until transfer
  task automatic send_req(logic [1:0] k, logic [15:0] sz, logic [15:0] pid, logic [5:0] pno);
    req_type <= k;
    size_mb <= sz;
    process_id <= pid;
    page_number <= pno;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    if (k == REQ_ADD && next_pid != 16'hFFFF) next_pid = next_pid + 1;
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_PAGE_MB) cur_psize = (val == 0) ? 1 : int'(val);
    else next_pid = '0;
  endtask

  task automatic random_req();
    logic [15:0] pid;
    if ($urandom_range(0, 9) < 6) begin
      pid = next_pid - 16'($urandom_range(0, 6));
      case ($urandom_range(0, 2))
        0: send_req(REQ_ADD, 16'($urandom_range(0, cur_psize * 8)), 16'($urandom), 6'd0);
        1: send_req(REQ_TRANSLATE, 16'($urandom), pid, 6'($urandom_range(0, 8)));
        default: send_req(REQ_DELETE, 16'($urandom), pid, 6'($urandom));
      endcase
    end else begin
      send_req(2'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
    end
    maybe_gap();
  endtask

  initial begin
    logic [12:0] ps_set[6];
    logic [12:0] fc_set[6];
    calm = 0;
    next_pid = '0;
    cur_psize = 1;
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = '0;
    in_valid = 0;
    req_type = '0;
    size_mb = '0;
    process_id = '0;
    page_number = '0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: zero size, too large, translate edges, unknown kind and id
    send_req(REQ_ADD, 16'd0, 16'd0, 6'd0);
    send_req(REQ_ADD, 16'hFFFF, 16'd0, 6'd0);
    send_req(REQ_ADD, 16'd5, 16'd0, 6'd0);
    send_req(REQ_ADD, 16'd64, 16'd0, 6'd0);
    for (int p = 0; p < 6; p++) send_req(REQ_TRANSLATE, 16'd0, 16'd3, 6'(p));
    send_req(REQ_TRANSLATE, 16'd0, 16'd3, 6'd63);
    send_req(REQ_TRANSLATE, 16'd0, 16'd1, 6'd0);
    send_req(REQ_TRANSLATE, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_req(2'd3, 16'hFFFF, 16'd3, 6'h3F);
    send_req(REQ_DELETE, 16'd0, 16'hFFFF, 6'd0);
    send_req(REQ_DELETE, 16'd0, 16'd3, 6'd0);
    drain();
    write_reg(CFG_PAGE_MB, 13'd0);
    send_req(REQ_ADD, 16'd7, 16'd0, 6'd0);

    // Fill every slot, then overflow the slot table
    for (int i = 0; i < 10; i++) send_req(REQ_ADD, 16'd1, 16'd0, 6'd0);
    calm = 1;
    send_req(REQ_ADD, 16'd0, 16'd0, 6'd0);
    // Free two slots and reuse them
    send_req(REQ_DELETE, 16'd0, 16'd6, 6'd0);
    send_req(REQ_DELETE, 16'd0, 16'd7, 6'd0);
    send_req(REQ_ADD, 16'd3, 16'd0, 6'd0);
    send_req(REQ_ADD, 16'd2, 16'd0, 6'd0);
    send_req(REQ_TRANSLATE, 16'd0, 16'd17, 6'd2);
    send_req(REQ_TRANSLATE, 16'd0, 16'd18, 6'd1);
    send_req(REQ_DELETE, 16'd0, 16'd17, 6'd0);
    send_req(REQ_TRANSLATE, 16'd0, 16'd17, 6'd1);
    send_req(REQ_DELETE, 16'd0, 16'd18, 6'd0);
    send_req(REQ_DELETE, 16'd0, 16'd18, 6'd0);
    calm = 0;
    drain();

    // Random phases over several register settings, extremes included
    ps_set = '{13'd1, 13'd8191, 13'd4096, 13'd0, 13'd3, 13'($urandom_range(1, 40))};
    fc_set = '{13'd64, 13'd127, 13'd8, 13'd0, 13'd20, 13'($urandom_range(1, 64))};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_PAGE_MB, ps_set[ph]);
      write_reg(CFG_FRAME_COUNT, fc_set[ph]);
      if (ph == 5) calm = 1;
      repeat (18) random_req();
      drain();
    end

    if (errors == 0)
      $display("paged_frame_allocator: match");
    else
      $display("paged_frame_allocator: mismatch");
    $finish;
  end

endmodule

/* sim.f */
sv/pfa_pkg.sv
sv/pfa_div.sv
sv/paged_frame_allocator.sv
bench/pfa_checker.sv
bench/testbench.sv
